// ----- design/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// shared constants, types and helpers of the scan point segmenter
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int ANGLE_STEPS = 360;
  localparam int ANGLE_W     = 9;
  localparam int DIST_W      = 16;
  localparam int OUT_CNT_W   = 9;

  // one segment never spans more than one rotation
  localparam int CNT_W       = $clog2(ANGLE_STEPS + 1);
  localparam int SUM_W       = DIST_W + CNT_W;
  // a wrapped segment joins two of them
  localparam int MCNT_W      = CNT_W + 1;
  localparam int MSUM_W      = SUM_W + 1;

  localparam int DIV_STEPS   = MSUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [ANGLE_W-1:0]   TOP_ANGLE = ANGLE_W'(ANGLE_STEPS - 1);
  localparam logic [OUT_CNT_W-1:0] CNT_SAT   = '1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLOSE = 5'b00010,
    S_END   = 5'b00100,
    S_DIV   = 5'b01000,
    S_LOAD  = 5'b10000
  } state_e;

  // fields of one result waiting on the divider
  typedef struct packed {
    logic [ANGLE_W-1:0]   start;
    logic [OUT_CNT_W-1:0] count;
    logic [DIST_W-1:0]    max;
    logic [DIST_W-1:0]    min;
    logic                 last;
  } res_t;

  function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [MCNT_W-1:0] cnt);
    logic [OUT_CNT_W-1:0] r;
    if (cnt > MCNT_W'(CNT_SAT)) begin
      r = CNT_SAT;
    end else begin
      r = cnt[OUT_CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/sps_div.sv -----
// ----------------------------------------------------------------------------
// sps_div
// restoring divider, one quotient bit per cycle, quotient clamped to 16 bits
// ----------------------------------------------------------------------------
module sps_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sps_pkg::MSUM_W-1:0] dividend_i,
  input  logic [sps_pkg::MCNT_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [sps_pkg::DIST_W-1:0] quotient_o
);
  import sps_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic [MCNT_W-1:0]    rem_q, rem_d;
  logic [MSUM_W-1:0]    quo_q;
  logic [MCNT_W-1:0]    dsr_q;
  logic [MCNT_W:0]      shifted;
  logic [MCNT_W:0]      diff;
  logic                 fits;

  assign shifted = {rem_q, quo_q[MSUM_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};
  assign rem_d   = fits ? diff[MCNT_W-1:0] : shifted[MCNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + DIV_CNT_W'(1);
      if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[MSUM_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = (|quo_q[MSUM_W-1:DIST_W]) ? '1 : quo_q[DIST_W-1:0];

endmodule

// ----- design/scan_point_segmenter.sv -----
// ----------------------------------------------------------------------------
// scan_point_segmenter
// splits one rotating range scan into runs of adjacent usable samples
// ----------------------------------------------------------------------------
// usage
//   input channel: one scan sample per request (angle, distance, usable,
//   end_of_scan), in angle order; in_stall_o is high while a sample is in work
//   output channel: one segment per request (start angle, count, truncated
//   mean, max, min, last_of_run marks the last segment caused by a sample)
//   a sample that reports nothing passes S_CLOSE only, and S_END too with the end mark
//   each reported segment then waits on the shared restoring divider
//   (26 mean bits, one per cycle, then done) and takes one output load;
//   held plus open segment at the end mark cost one more end pass
//   so one sample reports up to three segments, and its work takes longer while
//   the receiver stalls
//   the first segment of a scan is held back and reported at the end mark,
//   merged with the last segment when the two touch across angle zero
//   a stalled result stays in the output register; a new sample is still
//   taken meanwhile and work stops only when its own result needs that slot
//   reset empties the open and held segments and the output register
// ----------------------------------------------------------------------------
module scan_point_segmenter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample request
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sps_pkg::ANGLE_W-1:0]   angle_i,
  input  logic [sps_pkg::DIST_W-1:0]    distance_i,
  input  logic                          usable_i,
  input  logic                          end_of_scan_i,
  // segment request
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sps_pkg::ANGLE_W-1:0]   start_angle_o,
  output logic [sps_pkg::OUT_CNT_W-1:0] point_count_o,
  output logic [sps_pkg::DIST_W-1:0]    mean_distance_o,
  output logic [sps_pkg::DIST_W-1:0]    max_distance_o,
  output logic [sps_pkg::DIST_W-1:0]    min_distance_o,
  output logic                          last_of_run_o
);
  import sps_pkg::*;

  // sequencer
  state_e state_q, state_d;
  state_e ret_q, ret_d;

  // captured sample
  logic [ANGLE_W-1:0] in_angle_q;
  logic [DIST_W-1:0]  in_dist_q;
  logic               in_use_q;
  logic               in_end_q;

  // open segment
  logic               seg_open_q, seg_open_d;
  logic [ANGLE_W-1:0] prev_angle_q, prev_angle_d;
  logic [ANGLE_W-1:0] open_start_q, open_start_d;
  logic [SUM_W-1:0]   open_sum_q, open_sum_d;
  logic [CNT_W-1:0]   open_cnt_q, open_cnt_d;
  logic [DIST_W-1:0]  open_max_q, open_max_d;
  logic [DIST_W-1:0]  open_min_q, open_min_d;

  // first segment of the scan, held back
  logic               first_held_q, first_held_d;
  logic [ANGLE_W-1:0] held_start_q, held_start_d;
  logic [SUM_W-1:0]   held_sum_q, held_sum_d;
  logic [CNT_W-1:0]   held_cnt_q, held_cnt_d;
  logic [DIST_W-1:0]  held_max_q, held_max_d;
  logic [DIST_W-1:0]  held_min_q, held_min_d;

  // result waiting on the divider
  res_t res_q, res_d;

  // divider hookup
  logic              div_start;
  logic [MSUM_W-1:0] div_sum;
  logic [MCNT_W-1:0] div_cnt;
  logic              div_busy;
  logic              div_done;
  logic [DIST_W-1:0] div_quo;

  // output register
  logic               out_valid_q;
  res_t               out_res_q;
  logic [DIST_W-1:0]  out_mean_q;
  logic               out_free;
  logic               out_load;

  // helpers for the sample step
  logic               adjacent;
  logic               extend;
  logic               closing;
  logic               merge;
  state_e             after_close;
  logic [MCNT_W-1:0]  merge_cnt;
  logic [DIST_W-1:0]  merge_max;
  logic [DIST_W-1:0]  merge_min;

  assign in_stall_o = (state_q != S_IDLE);

  assign adjacent = ({1'b0, in_angle_q} == ({1'b0, prev_angle_q} + (ANGLE_W + 1)'(1)));
  assign extend   = in_use_q && seg_open_q && adjacent;
  assign closing  = seg_open_q && !extend;
  assign after_close = in_end_q ? S_END : S_IDLE;

  // wrap-around: last angle reached and the held segment starts at zero
  assign merge = seg_open_q && first_held_q && (held_start_q == '0) &&
                 (prev_angle_q == TOP_ANGLE);
  assign merge_cnt = MCNT_W'(open_cnt_q) + MCNT_W'(held_cnt_q);
  assign merge_max = (open_max_q > held_max_q) ? open_max_q : held_max_q;
  assign merge_min = (open_min_q < held_min_q) ? open_min_q : held_min_q;

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    res_d        = res_q;
    div_start    = 1'b0;
    div_sum      = '0;
    div_cnt      = '0;
    seg_open_d   = seg_open_q;
    prev_angle_d = prev_angle_q;
    open_start_d = open_start_q;
    open_sum_d   = open_sum_q;
    open_cnt_d   = open_cnt_q;
    open_max_d   = open_max_q;
    open_min_d   = open_min_q;
    first_held_d = first_held_q;
    held_start_d = held_start_q;
    held_sum_d   = held_sum_q;
    held_cnt_d   = held_cnt_q;
    held_max_d   = held_max_q;
    held_min_d   = held_min_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CLOSE;
        end
      end

      S_CLOSE: begin
        state_d = after_close;
        if (closing) begin
          seg_open_d = 1'b0;
          if (first_held_q) begin
            // report the closed segment; more follow when the scan ends
            div_start = 1'b1;
            div_sum   = MSUM_W'(open_sum_q);
            div_cnt   = MCNT_W'(open_cnt_q);
            res_d     = '{start: open_start_q, count: sat_count(MCNT_W'(open_cnt_q)),
                          max: open_max_q, min: open_min_q, last: !in_end_q};
            ret_d     = after_close;
            state_d   = S_DIV;
          end else begin
            first_held_d = 1'b1;
            held_start_d = open_start_q;
            held_sum_d   = open_sum_q;
            held_cnt_d   = open_cnt_q;
            held_max_d   = open_max_q;
            held_min_d   = open_min_q;
          end
        end
        if (extend) begin
          open_sum_d = open_sum_q + SUM_W'(in_dist_q);
          open_cnt_d = open_cnt_q + CNT_W'(1);
          if (in_dist_q > open_max_q) open_max_d = in_dist_q;
          if (in_dist_q < open_min_q) open_min_d = in_dist_q;
        end else if (in_use_q) begin
          open_start_d = in_angle_q;
          open_sum_d   = SUM_W'(in_dist_q);
          open_cnt_d   = CNT_W'(1);
          open_max_d   = in_dist_q;
          open_min_d   = in_dist_q;
        end
        if (in_use_q) begin
          seg_open_d   = 1'b1;
          prev_angle_d = in_angle_q;
        end
      end

      S_END: begin
        state_d = S_IDLE;
        if (merge) begin
          div_start    = 1'b1;
          div_sum      = MSUM_W'(open_sum_q) + MSUM_W'(held_sum_q);
          div_cnt      = merge_cnt;
          res_d        = '{start: open_start_q, count: sat_count(merge_cnt),
                           max: merge_max, min: merge_min, last: 1'b1};
          seg_open_d   = 1'b0;
          first_held_d = 1'b0;
          ret_d        = S_IDLE;
          state_d      = S_DIV;
        end else if (first_held_q) begin
          // held one first, the open one on the next pass
          div_start    = 1'b1;
          div_sum      = MSUM_W'(held_sum_q);
          div_cnt      = MCNT_W'(held_cnt_q);
          res_d        = '{start: held_start_q, count: sat_count(MCNT_W'(held_cnt_q)),
                           max: held_max_q, min: held_min_q, last: !seg_open_q};
          first_held_d = 1'b0;
          ret_d        = seg_open_q ? S_END : S_IDLE;
          state_d      = S_DIV;
        end else if (seg_open_q) begin
          div_start  = 1'b1;
          div_sum    = MSUM_W'(open_sum_q);
          div_cnt    = MCNT_W'(open_cnt_q);
          res_d      = '{start: open_start_q, count: sat_count(MCNT_W'(open_cnt_q)),
                         max: open_max_q, min: open_min_q, last: 1'b1};
          seg_open_d = 1'b0;
          ret_d      = S_IDLE;
          state_d    = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          state_d = S_LOAD;
        end
      end

      S_LOAD: begin
        if (out_free) begin
          state_d = ret_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // the output slot frees when empty or taken in this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_LOAD) && out_free;

  sps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_sum),
    .divisor_i  (div_cnt),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      seg_open_q   <= 1'b0;
      first_held_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      seg_open_q   <= seg_open_d;
      first_held_q <= first_held_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      in_angle_q <= angle_i;
      in_dist_q  <= distance_i;
      in_use_q   <= usable_i && ({1'b0, angle_i} < (ANGLE_W + 1)'(ANGLE_STEPS));
      in_end_q   <= end_of_scan_i;
    end
    prev_angle_q <= prev_angle_d;
    open_start_q <= open_start_d;
    open_sum_q   <= open_sum_d;
    open_cnt_q   <= open_cnt_d;
    open_max_q   <= open_max_d;
    open_min_q   <= open_min_d;
    held_start_q <= held_start_d;
    held_sum_q   <= held_sum_d;
    held_cnt_q   <= held_cnt_d;
    held_max_q   <= held_max_d;
    held_min_q   <= held_min_d;
    res_q        <= res_d;
    if (out_load) begin
      out_res_q  <= res_q;
      out_mean_q <= div_quo;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign start_angle_o   = out_res_q.start;
  assign point_count_o   = out_res_q.count;
  assign mean_distance_o = out_mean_q;
  assign max_distance_o  = out_res_q.max;
  assign min_distance_o  = out_res_q.min;
  assign last_of_run_o   = out_res_q.last;

  // a reported mean always lies within the segment's range
  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_distance_o <= mean_distance_o) &&
                    (mean_distance_o <= max_distance_o) && (point_count_o != '0))
    else $error("segment mean outside min/max or empty segment");

  // the divider is never restarted while it works
  a_div_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // open and held segments carry at least one point and a sane range
  a_segments_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_open_q |-> (open_cnt_q != '0) && (open_min_q <= open_max_q)) and
    (first_held_q |-> (held_cnt_q != '0) && (held_min_q <= held_max_q)))
    else $error("segment state inconsistent");

endmodule
